/* hdl/qrr_pkg.sv */
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared types and constants for the quadratic real-root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrr_pkg;

	localparam int COEF_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OUT_W         = 40;
	localparam int STATUS_W      = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_TWO   = 2'd0,
		ST_ONE   = 2'd1,
		ST_NONE  = 2'd2,
		ST_AZERO = 2'd3
	} status_t;

	typedef logic signed [OUT_W-1:0] root_t;

endpackage

`default_nettype wire

/* hdl/qrr_if.sv */
// ----------------------------------------------------------------------------
// qrr_coef_if / qrr_root_if
// Valid/ready channels for coefficient requests and root results.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrr_coef_if #(
	parameter int COEF_BITS = qrr_pkg::COEF_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [COEF_BITS-1:0] coef_a;
	logic signed [COEF_BITS-1:0] coef_b;
	logic signed [COEF_BITS-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_root_if;
	logic                  valid;
	logic                  ready;
	qrr_pkg::status_t      root_status;
	qrr_pkg::root_t        root_first;
	qrr_pkg::root_t        root_second;

	modport source (output valid, root_status, root_first, root_second, input ready);
	modport sink   (input valid, root_status, root_first, root_second, output ready);
endinterface

`default_nettype wire

/* hdl/quadratic_real_roots.sv */
// ----------------------------------------------------------------------------
// quadratic_real_roots
// Pipelined solver for the real roots of a*x*x + b*x + c in fixed point.
// ----------------------------------------------------------------------------
// Accepts one equation per cycle unless stalled, and returns one result per
// equation, in order. There are RW = COEF_BITS + FRAC_BITS + 1 square root
// cells and QW = COEF_BITS + FRAC_BITS + 2 division cells per root, each
// resolving one bit. The whole pipeline holds when the result register is
// full and not taken. Roots are signed with FRAC_BITS + 1 fraction bits,
// truncated toward zero and saturated to 40 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_real_roots #(
	parameter int COEF_BITS = qrr_pkg::COEF_BITS_DEF,
	parameter int FRAC_BITS = qrr_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	qrr_coef_if.sink   coef,
	qrr_root_if.source root
);
	import qrr_pkg::*;

	localparam int CB   = COEF_BITS;
	localparam int FB   = FRAC_BITS;
	localparam int DW   = 2*CB + 2;
	localparam int NW   = 2*CB + 1 + 2*FB;
	localparam int RW   = (NW + 1) / 2;
	localparam int NPW  = 2*RW;
	localparam int RMW  = RW + 3;
	localparam int NBW  = CB + FB + 1;
	localparam int DVW  = CB + 1;
	localparam int QW   = CB + FB + 2;
	localparam int NMW  = QW + 1;
	localparam int VW   = (QW + 1 > OUT_W) ? QW + 1 : OUT_W + 1;
	localparam int SQS  = STATUS_W + 1 + DVW + NBW;
	localparam int LAT  = RW + QW + 4;

	logic en;
	logic [LAT-2:0] vld_q;

	logic signed [2*CB-1:0] bb_s1, ac_s1;
	logic signed [CB-1:0]   a_s1, b_s1;

	logic signed [DW-1:0]  d_c;
	logic [CB-1:0]         a_abs_c;
	status_t               st_c;
	logic signed [NBW-1:0] nb_c;

	logic [RMW-1:0] sq_rem  [0:RW];
	logic [RW-1:0]  sq_root [0:RW];
	logic [NPW-1:0] sq_n    [0:RW];
	logic [SQS-1:0] sq_side [0:RW];

	logic signed [NBW-1:0] nb_q;
	logic [DVW-1:0]        dv_q;
	logic                  asg_q;
	status_t               stq_c;
	logic signed [NMW-1:0] nump_c, numm_c;

	logic [QW-1:0]   p_num  [0:QW];
	logic [DVW-1:0]  p_rem  [0:QW];
	logic [DVW-1:0]  p_dv   [0:QW];
	logic [2:0]      p_side [0:QW];
	logic [QW-1:0]   m_num  [0:QW];
	logic [DVW-1:0]  m_rem  [0:QW];
	logic [DVW-1:0]  m_dv   [0:QW];
	logic [0:0]      m_side [0:QW];

	logic  out_v_q;
	status_t out_st_q;
	root_t out_first_q, out_second_q;
	root_t first_c, second_c;
	status_t fin_st_c;

	function automatic root_t sat_root(input logic neg, input logic [QW-1:0] mag);
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] vmax;
		logic signed [VW-1:0] vmin;
		v    = VW'(mag);
		v    = neg ? -v : v;
		vmax = {{(VW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
		vmin = {{(VW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
		if (v > vmax) begin
			return vmax[OUT_W-1:0];
		end else if (v < vmin) begin
			return vmin[OUT_W-1:0];
		end
		return v[OUT_W-1:0];
	endfunction

	assign en         = !out_v_q || root.ready;
	assign coef.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[LAT-3:0], coef.valid};
			out_v_q <= vld_q[LAT-2];
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= coef.coef_b * coef.coef_b;
			ac_s1 <= coef.coef_a * coef.coef_c;
			a_s1  <= coef.coef_a;
			b_s1  <= coef.coef_b;
		end
	end

	// discriminant and classification
	always_comb begin
		d_c     = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
		a_abs_c = a_s1[CB-1] ? (~a_s1 + 1'b1) : a_s1;
		nb_c    = -(NBW'(b_s1) <<< FB);
		if (a_s1 == '0) begin
			st_c = ST_AZERO;
		end else if (d_c[DW-1]) begin
			st_c = ST_NONE;
		end else if (d_c == '0) begin
			st_c = ST_ONE;
		end else begin
			st_c = ST_TWO;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_n[0]    <= d_c[DW-1] ? '0 : (NPW'(d_c[DW-2:0]) << (2*FB));
			sq_side[0] <= {st_c, a_s1[CB-1], a_abs_c, 1'b0, nb_c};
		end
	end

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		qrr_sqrt_cell #(.RW(RW), .NPW(NPW), .SIDE_W(SQS)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.n_i    (sq_n[i]),
			.side_i (sq_side[i]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1]),
			.n_o    (sq_n[i+1]),
			.side_o (sq_side[i+1])
		);
	end

	// numerators
	always_comb begin
		nb_q   = sq_side[RW][NBW-1:0];
		dv_q   = sq_side[RW][NBW +: DVW];
		asg_q  = sq_side[RW][NBW+DVW];
		stq_c  = status_t'(sq_side[RW][SQS-1 -: STATUS_W]);
		nump_c = NMW'(nb_q) + NMW'(sq_root[RW]);
		numm_c = NMW'(nb_q) - NMW'(sq_root[RW]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_rem[0]  <= '0;
			p_dv[0]   <= dv_q;
			p_num[0]  <= nump_c[NMW-1] ? QW'(-nump_c) : QW'(nump_c);
			p_side[0] <= {stq_c, nump_c[NMW-1] ^ asg_q};
			m_rem[0]  <= '0;
			m_dv[0]   <= dv_q;
			m_num[0]  <= numm_c[NMW-1] ? QW'(-numm_c) : QW'(numm_c);
			m_side[0] <= numm_c[NMW-1] ^ asg_q;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		qrr_div_cell #(.QW(QW), .DVW(DVW), .SIDE_W(3)) u_plus (
			.clk    (clk),
			.en     (en),
			.rem_i  (p_rem[j]),
			.num_i  (p_num[j]),
			.dv_i   (p_dv[j]),
			.side_i (p_side[j]),
			.rem_o  (p_rem[j+1]),
			.num_o  (p_num[j+1]),
			.dv_o   (p_dv[j+1]),
			.side_o (p_side[j+1])
		);
		qrr_div_cell #(.QW(QW), .DVW(DVW), .SIDE_W(1)) u_minus (
			.clk    (clk),
			.en     (en),
			.rem_i  (m_rem[j]),
			.num_i  (m_num[j]),
			.dv_i   (m_dv[j]),
			.side_i (m_side[j]),
			.rem_o  (m_rem[j+1]),
			.num_o  (m_num[j+1]),
			.dv_o   (m_dv[j+1]),
			.side_o (m_side[j+1])
		);
	end

	// sign, saturation and zeroing
	always_comb begin
		fin_st_c = status_t'(p_side[QW][2:1]);
		first_c  = sat_root(p_side[QW][0], p_num[QW]);
		second_c = sat_root(m_side[QW][0], m_num[QW]);
		case (fin_st_c)
			ST_TWO: begin
			end
			ST_ONE: begin
				second_c = '0;
			end
			default: begin
				first_c  = '0;
				second_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_st_q     <= fin_st_c;
			out_first_q  <= first_c;
			out_second_q <= second_c;
		end
	end

	assign root.valid       = out_v_q;
	assign root.root_status = out_st_q;
	assign root.root_first  = out_first_q;
	assign root.root_second = out_second_q;

endmodule

`default_nettype wire

/* hdl/qrr_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrr_sqrt_cell
// One digit-by-digit square root step: resolves one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_sqrt_cell #(
	parameter int RW     = 33,
	parameter int NPW    = 66,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [RW+2:0]     rem_i,
	input  wire logic [RW-1:0]     root_i,
	input  wire logic [NPW-1:0]    n_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic      [RW+2:0]     rem_o,
	output logic      [RW-1:0]     root_o,
	output logic      [NPW-1:0]    n_o,
	output logic      [SIDE_W-1:0] side_o
);
	logic [RW+2:0] rsh;
	logic [RW+2:0] trial;
	logic          ge;

	always_comb begin
		rsh   = {rem_i[RW:0], n_i[NPW-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		ge    = (rsh >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? (rsh - trial) : rsh;
			root_o <= {root_i[RW-2:0], ge};
			n_o    <= {n_i[NPW-3:0], 2'b00};
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

/* hdl/qrr_div_cell.sv */
// ----------------------------------------------------------------------------
// qrr_div_cell
// One restoring division step: resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_div_cell #(
	parameter int QW     = 34,
	parameter int DVW    = 17,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DVW-1:0]    rem_i,
	input  wire logic [QW-1:0]     num_i,
	input  wire logic [DVW-1:0]    dv_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic      [DVW-1:0]    rem_o,
	output logic      [QW-1:0]     num_o,
	output logic      [DVW-1:0]    dv_o,
	output logic      [SIDE_W-1:0] side_o
);
	logic [DVW:0] r2;
	logic [DVW:0] diff;
	logic         ge;

	always_comb begin
		r2   = {rem_i, num_i[QW-1]};
		diff = r2 - {1'b0, dv_i};
		ge   = (r2 >= {1'b0, dv_i});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[DVW-1:0] : r2[DVW-1:0];
			num_o  <= {num_i[QW-2:0], ge};
			dv_o   <= dv_i;
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

/* hdl/qrr_chk.sv */
// ----------------------------------------------------------------------------
// qrr_chk
// Port-level checks for the quadratic real-root solver, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire qrr_pkg::status_t   out_status,
	input wire qrr_pkg::root_t     out_first,
	input wire qrr_pkg::root_t     out_second
);
	import qrr_pkg::*;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with empty result register");

	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == ST_NONE || out_status == ST_AZERO)
			|-> (out_first == '0 && out_second == '0))
		else $error("roots not zero without real roots");

	a_double_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_ONE |-> out_second == '0)
		else $error("second root not zero for double root");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status)
			&& $stable(out_first) && $stable(out_second))
		else $error("stalled result changed");

endmodule

bind quadratic_real_roots qrr_chk u_qrr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (coef.valid),
	.in_ready   (coef.ready),
	.out_valid  (root.valid),
	.out_ready  (root.ready),
	.out_status (root.root_status),
	.out_first  (root.root_first),
	.out_second (root.root_second)
);

`default_nettype wire
